[rtl/midi_channel_message_parser_core_defines.svh]
// assertion macros shared by the midi channel message parser rtl
// expects clk and rst in the scope of the module that uses them
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_CORE_DEFINES_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define MCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcp same-cycle check failed");

// next-cycle implication
`define MCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcp next-cycle check failed");

`endif

[rtl/mcp_pkg.sv]
// package for the midi channel message parser
// constants, status kinds and the parser result struct; no dependencies
`timescale 1ns / 1ps

package mcp_pkg;

  localparam logic [15:0] ResetChannelMask = 16'hFFFF;

  // upper nibble of a status byte
  localparam logic [3:0] KindProgram  = 4'hC;
  localparam logic [3:0] KindPressure = 4'hD;
  localparam logic [3:0] KindSystem   = 4'hF;

  localparam logic [1:0] LenOne = 2'd1;
  localparam logic [1:0] LenTwo = 2'd2;

  typedef struct packed {
    logic       emit;
    logic [7:0] status_byte;
    logic [3:0] channel;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } result_t;

endpackage

[rtl/midi_channel_message_parser_core.sv]
// top level of the midi channel message parser: input register, parser, result register
// depends on mcp_pkg, mcp_parse_state and midi_channel_message_parser_core_defines.svh
`timescale 1ns / 1ps
`include "midi_channel_message_parser_core_defines.svh"

// Takes one MIDI byte per transfer and gives one result transfer for each completed
// channel message (status, channel, up to two data bytes), with running status and a
// per-channel mask written through cfg_write_enable/cfg_write_data (reset 0xFFFF).
// A byte is taken every cycle when the result side does not stall. An input byte
// passes through the input register, then the parser update that loads the result
// register. System bytes 0xF0-0xFF are dropped.

module midi_channel_message_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  input  logic        midi_valid,
  output logic        midi_stall,
  input  logic [7:0]  midi_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  status_byte,
  output logic [3:0]  channel,
  output logic [6:0]  data_first,
  output logic [6:0]  data_second
);
  import mcp_pkg::*;

  logic [15:0] chan_enable;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;
  logic        step;
  result_t     result;

  assign advance    = !result_valid || !result_stall;
  assign step       = in_full && advance;
  assign midi_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_enable <= ResetChannelMask;
    end else if (cfg_write_enable) begin
      chan_enable <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (midi_valid && !midi_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (midi_valid && !midi_stall) begin
      in_byte <= midi_byte;
    end
  end

  mcp_parse_state u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .midi_byte    (in_byte),
    .chan_enable  (chan_enable),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      status_byte <= result.status_byte;
      channel     <= result.channel;
      data_first  <= result.data_first;
      data_second <= result.data_second;
    end
  end

  `MCP_ASSERT_NOW(a_stall_only_when_blocked, midi_stall, in_full && result_valid && result_stall)
  `MCP_ASSERT_NOW(a_result_is_channel_status, result_valid, status_byte[7] && status_byte[7:4] != KindSystem)
  `MCP_ASSERT_NEXT(a_held_input_kept, in_full && !advance, in_full && $stable(in_byte))

endmodule

[rtl/mcp_parse_state.sv]
// parser state: running status, channel mask check and data assembly
// depends on mcp_pkg and midi_channel_message_parser_core_defines.svh
`timescale 1ns / 1ps
`include "midi_channel_message_parser_core_defines.svh"

module mcp_parse_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      midi_byte,
  input  logic [15:0]     chan_enable,
  output mcp_pkg::result_t result
);
  import mcp_pkg::*;

  logic [7:0] current_status, current_status_next;
  logic [1:0] needed_length, needed_length_next;
  logic [1:0] byte_position, byte_position_next;
  logic [7:0] saved_status, saved_status_next;
  logic [1:0] saved_length, saved_length_next;
  logic [3:0] last_channel, last_channel_next;
  logic [6:0] data0, data0_next;
  logic [6:0] data1, data1_next;

  logic [3:0] kind;
  logic [7:0] cur_mid;
  logic [1:0] need_mid;
  logic [1:0] pos_mid;
  logic       done;

  assign kind = midi_byte[7:4];

  always_comb begin
    cur_mid            = current_status;
    need_mid           = needed_length;
    pos_mid            = byte_position;
    saved_status_next  = saved_status;
    saved_length_next  = saved_length;
    last_channel_next  = last_channel;
    data0_next         = data0;
    data1_next         = data1;
    if (midi_byte[7]) begin
      if (kind != KindSystem) begin
        last_channel_next = midi_byte[3:0];
        if (chan_enable[midi_byte[3:0]]) begin
          cur_mid           = midi_byte;
          saved_status_next = midi_byte;
          pos_mid           = 2'd0;
          need_mid          = (kind == KindProgram || kind == KindPressure) ? LenOne : LenTwo;
          saved_length_next = need_mid;
        end
      end
    end else begin
      if (current_status == 8'd0 && needed_length == 2'd0) begin
        cur_mid  = saved_status;
        need_mid = saved_length;
      end
      if (byte_position[0]) begin
        data1_next = midi_byte[6:0];
      end else begin
        data0_next = midi_byte[6:0];
      end
      pos_mid = byte_position + 2'd1;
    end
  end

  // message completion and return to idle
  always_comb begin
    current_status_next = cur_mid;
    needed_length_next  = need_mid;
    byte_position_next  = pos_mid;
    done                = 1'b0;
    if (pos_mid >= need_mid) begin
      byte_position_next = 2'd0;
      if (cur_mid != 8'd0) begin
        done                = 1'b1;
        current_status_next = 8'd0;
        needed_length_next  = 2'd0;
      end
    end
  end

  always_comb begin
    result.emit        = done;
    result.status_byte = cur_mid;
    result.channel     = last_channel_next;
    result.data_first  = data0_next;
    result.data_second = data1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_status <= 8'd0;
      needed_length  <= 2'd0;
      byte_position  <= 2'd0;
      saved_status   <= 8'd0;
      saved_length   <= 2'd0;
      last_channel   <= 4'd0;
      data0          <= 7'd0;
      data1          <= 7'd0;
    end else if (step) begin
      current_status <= current_status_next;
      needed_length  <= needed_length_next;
      byte_position  <= byte_position_next;
      saved_status   <= saved_status_next;
      saved_length   <= saved_length_next;
      last_channel   <= last_channel_next;
      data0          <= data0_next;
      data1          <= data1_next;
    end
  end

  `MCP_ASSERT_NOW(a_busy_has_length, 1'b1, (current_status == 8'd0) == (needed_length == 2'd0))
  `MCP_ASSERT_NOW(a_position_in_message, current_status != 8'd0, byte_position < needed_length)
  `MCP_ASSERT_NEXT(a_emit_goes_idle, step && done, current_status == 8'd0 && byte_position == 2'd0)

endmodule
